// ----- rtl/cstp_pkg.sv -----
// ----------------------------------------------------------------------------
// cstp_pkg
// Shared types and constants for one cache set with tree pseudo-LRU
// replacement: payload structs, controller commands and state encoding.
// ----------------------------------------------------------------------------
package cstp_pkg;

   // payload field widths
   localparam int TAG_FIELD_W   = 12;
   localparam int WAY_FIELD_W   = 3;
   localparam int STATE_FIELD_W = 3;

   // defaults for the top-level parameters
   localparam int DEFAULT_WAYS     = 8;
   localparam int DEFAULT_TAG_BITS = 12;

   // request actions
   localparam logic ACT_LOOKUP = 1'b0;
   localparam logic ACT_PLACE  = 1'b1;

   // coherence state codes
   localparam logic [STATE_FIELD_W-1:0] LINE_MODIFIED = 3'd0;
   localparam logic [STATE_FIELD_W-1:0] LINE_INVALID  = 3'd3;

   typedef struct packed {
      logic                     action;
      logic [TAG_FIELD_W-1:0]   tag;
      logic [STATE_FIELD_W-1:0] line_state;
   } req_type;

   typedef struct packed {
      logic                     hit;
      logic [WAY_FIELD_W-1:0]   way;
      logic [STATE_FIELD_W-1:0] found_state;
      logic                     evicted;
      logic                     evicted_modified;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

   typedef enum logic {
      CTRL_IDLE,
      CTRL_EXEC
   } ctrl_state_type;

endpackage

// ----- rtl/cstp_ctrl.sv -----
// ----------------------------------------------------------------------------
// cstp_ctrl
// Controller: takes a request into the datapath, then runs it once the
// result register is free or draining, and holds the result valid flag.
// ----------------------------------------------------------------------------
module cstp_ctrl
   import cstp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // state and result flag registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTRL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd.load  = 1'b0;
      cmd.exec  = 1'b0;
      case (state_ff)
         CTRL_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = CTRL_EXEC;
            end
         end
         CTRL_EXEC: begin
            // run only when the result register is free or draining
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.exec = 1'b1;
               state_in = CTRL_IDLE;
            end
         end
         default: begin
            state_in = CTRL_IDLE;
         end
      endcase
   end

   // result flag: set on execute, cleared on transfer
   always_comb begin
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/cstp_datapath.sv -----
// ----------------------------------------------------------------------------
// cstp_datapath
// Way storage, parallel tag compare, free-way search, pseudo-LRU tree walk
// and the request and result registers.
// ----------------------------------------------------------------------------
module cstp_datapath
   import cstp_pkg::*;
#(
   parameter int WAYS     = DEFAULT_WAYS,
   parameter int TAG_BITS = DEFAULT_TAG_BITS
)
(
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  req_type req_data,
   output rsp_type rsp_data
);

   localparam int WAY_W  = $clog2(WAYS);
   localparam int TREE_W = WAYS - 1;
   localparam int STEPS  = $clog2(WAYS);

   req_type                  req_ff;
   rsp_type                  rsp_ff, rsp_in;
   logic [WAYS-1:0]          present_ff;
   logic [TAG_BITS-1:0]      tag_ff   [WAYS];
   logic [STATE_FIELD_W-1:0] state_ff [WAYS];
   logic [TREE_W-1:0]        plru_ff, plru_in;

   logic [TAG_BITS+TAG_FIELD_W-1:0] tag_ext;
   logic [TAG_BITS-1:0]             tag_cmp;
   logic                            is_place;

   logic                     hit_any, free_any;
   logic [WAY_W-1:0]         hit_way, free_way, victim_way, touch_way, write_way;
   logic [STATE_FIELD_W-1:0] hit_state, victim_state;

   logic [TREE_W-1:0] touch_tree, victim_tree;
   int                ts, te, td, tm;
   int                vs, ve, vd, vm;

   // request tag, zero-extended or cut to the stored width
   assign tag_ext  = {{TAG_BITS{1'b0}}, req_ff.tag};
   assign tag_cmp  = tag_ext[TAG_BITS-1:0];
   assign is_place = (req_ff.action == ACT_PLACE);

   // lowest matching way and lowest empty or invalid way
   always_comb begin
      hit_any   = 1'b0;
      hit_way   = '0;
      hit_state = '0;
      free_any  = 1'b0;
      free_way  = '0;
      for (int i = 0; i < WAYS; i++) begin
         if (!hit_any && present_ff[i] && (tag_ff[i] == tag_cmp)) begin
            hit_any   = 1'b1;
            hit_way   = WAY_W'(i);
            hit_state = state_ff[i];
         end
         if (!free_any && (!present_ff[i] || (state_ff[i] == LINE_INVALID))) begin
            free_any = 1'b1;
            free_way = WAY_W'(i);
         end
      end
   end

   assign touch_way = is_place ? free_way : hit_way;

   // tree walk that steers away from the touched way
   always_comb begin
      touch_tree = plru_ff;
      ts = 0;
      te = WAYS - 2;
      td = 0;
      tm = 0;
      for (int k = 0; k < STEPS; k++) begin
         if (te - ts > 0) begin
            td = (te - ts) >> 1;
            tm = ts + td;
            touch_tree[tm] = (int'(touch_way) <= tm);
            if (!touch_tree[tm]) begin
               ts = ts + td + 1;
            end else begin
               te = te - (td + 1);
            end
         end
      end
      touch_tree[te] = !touch_way[0];
   end

   // victim walk, flipping every bit on the path
   always_comb begin
      victim_tree = plru_ff;
      vs = 0;
      ve = WAYS - 2;
      vd = 0;
      vm = 0;
      for (int k = 0; k < STEPS; k++) begin
         if (ve - vs > 0) begin
            vd = (ve - vs) >> 1;
            vm = vs + vd;
            victim_tree[vm] = !victim_tree[vm];
            if (!victim_tree[vm]) begin
               vs = vs + vd + 1;
            end else begin
               ve = ve - (vd + 1);
            end
         end
      end
      victim_tree[ve] = !victim_tree[ve];
      victim_way = WAY_W'(ve + (victim_tree[ve] ? 0 : 1));
   end

   // state of the victim way
   always_comb begin
      victim_state = '0;
      for (int i = 0; i < WAYS; i++) begin
         if (victim_way == WAY_W'(i)) begin
            victim_state = state_ff[i];
         end
      end
   end

   assign write_way = free_any ? free_way : victim_way;

   // next tree and result
   always_comb begin
      plru_in = plru_ff;
      rsp_in  = '0;
      if (is_place) begin
         rsp_in.way = WAY_FIELD_W'({{WAY_FIELD_W{1'b0}}, write_way});
         if (free_any) begin
            plru_in = touch_tree;
         end else begin
            plru_in                 = victim_tree;
            rsp_in.evicted          = 1'b1;
            rsp_in.evicted_modified = (victim_state == LINE_MODIFIED);
         end
      end else if (hit_any) begin
         plru_in            = touch_tree;
         rsp_in.hit         = 1'b1;
         rsp_in.way         = WAY_FIELD_W'({{WAY_FIELD_W{1'b0}}, hit_way});
         rsp_in.found_state = hit_state;
      end
   end

   // control state: present flags and tree bits
   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
         plru_ff    <= '0;
      end else if (cmd.exec) begin
         plru_ff <= plru_in;
         if (is_place) begin
            present_ff[write_way] <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
         if (is_place) begin
            tag_ff[write_way]   <= tag_cmp;
            state_ff[write_way] <= req_ff.line_state;
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ----- rtl/cache_set_tree_plru_top.sv -----
// Each request is captured, then run (tag compare and tree update) once the result
// register is free or draining; a new request is taken only after that run.
// A waiting result does not block the next request from being captured.
// Reset (synchronous): clears the present flags and the pseudo-LRU bits;
// stored tags and states are left as they are and are read only for present ways.
// ----------------------------------------------------------------------------
// cache_set_tree_plru_top
// One set of a set-associative cache with tree pseudo-LRU replacement:
// lookup by tag, or place a line into a free way or a tree-chosen victim.
// ----------------------------------------------------------------------------
module cache_set_tree_plru_top
   import cstp_pkg::*;
#(
   parameter int WAYS     = DEFAULT_WAYS,
   parameter int TAG_BITS = DEFAULT_TAG_BITS
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type cmd;

   // controller
   cstp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // datapath
   cstp_datapath #(
      .WAYS     (WAYS),
      .TAG_BITS (TAG_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

`ifndef SYNTHESIS
   // busy for the cycle after a request transfer
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   // a hit never reports an eviction
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.hit) |-> !rsp_data.evicted)
      else $error("hit with eviction");

   // modified flag only with an eviction
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.evicted_modified) |-> rsp_data.evicted)
      else $error("modified flag without eviction");
`endif

endmodule
